/* rtl/smset_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted multiset store package
// Shared types and codes for the sorted key row and its cells.
// ----------------------------------------------------------------------------
package smset_pkg;

    // Operation codes carried in the request.
    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_SEARCH = 2'd2;
    localparam logic [1:0] MODE_CLEAR  = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam int KEY_W = 32;

    typedef logic signed [KEY_W-1:0] t_key;

    // Control broadcast to every cell of the row.
    typedef struct packed {
        logic do_ins;   // Insert the key (store not full).
        logic do_rem;   // Remove the first match (match exists).
        t_key key;      // Key of the current request.
    } t_cell_ctl;

    // Compare flags a cell hands to its right neighbor.
    typedef struct packed {
        logic le;       // Held key is valid and not above the request key.
        logic lt;       // Held key is valid and below the request key.
    } t_cell_flags;

endpackage

/* rtl/smset_cell.sv */
// ----------------------------------------------------------------------------
// Sorted multiset cell
// Holds one key of the ordered row, compares it with the request key and
// shifts keys to or from its neighbors on insert and remove.
// ----------------------------------------------------------------------------
module smset_cell #(
    parameter int CW  = 5,
    parameter int IDX = 0
) (
    input  logic                   i_clk,
    input  smset_pkg::t_cell_ctl   i_ctl,
    input  logic [CW-1:0]          i_count,
    input  smset_pkg::t_key        i_left_key,
    input  smset_pkg::t_cell_flags i_left_flags,
    input  smset_pkg::t_key        i_right_key,
    output smset_pkg::t_key        o_key,
    output smset_pkg::t_cell_flags o_flags,
    output logic                   o_first_eq,
    output smset_pkg::t_key        o_last_key
);
    import smset_pkg::*;

    t_key r_key;
    t_key n_key;
    logic w_valid;
    logic w_last;

    // Occupancy of this slot follows from the key count.
    assign w_valid = i_count > CW'(IDX);
    assign w_last  = i_count == CW'(IDX + 1);

    // Local compares against the request key.
    assign o_flags.le = w_valid && (r_key <= i_ctl.key);
    assign o_flags.lt = w_valid && (r_key <  i_ctl.key);

    // This slot holds the first match when every key to its left is smaller.
    assign o_first_eq = w_valid && (r_key == i_ctl.key) && i_left_flags.lt;

    assign o_key      = r_key;
    assign o_last_key = w_last ? r_key : '0;

    // Insert keeps smaller-or-equal keys, drops the new key at the boundary
    // and shifts the rest right; remove shifts from the match onward left.
    always_comb begin
        n_key = r_key;
        if (i_ctl.do_ins && !o_flags.le) begin
            n_key = i_left_flags.le ? i_ctl.key : i_left_key;
        end else if (i_ctl.do_rem && !o_flags.lt) begin
            n_key = i_right_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule

/* rtl/sorted_multiset_store.sv */
// ----------------------------------------------------------------------------
// Sorted multiset store
// A row of key cells kept in ascending signed order with insert, remove of
// the first match, search and clear, reporting count and extremes per request.
// ----------------------------------------------------------------------------
// The row updates on the edge that takes the request, and the result is
// registered into the output once the output register is free to take it.
// A new request is not taken until the previous result has been loaded; the
// row updates first and the extremes are selected when the result is loaded.
// Reset clears the key count and the output; cell keys are left as they are
// and need no clearing pass, since slots beyond the count are never read.
// ----------------------------------------------------------------------------
module sorted_multiset_store #(
    parameter int CAPACITY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // Fields from bit 0: mode[1:0], key[33:2], zero fill[39:34].
    input  logic [39:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // Fields from bit 0: status[1:0], hit[2], count[7:3], smallest[39:8],
    // largest[71:40], is_empty[72], zero fill[79:73].
    output logic [79:0] o_m_axis_tdata
);
    import smset_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    logic [1:0]  w_mode;
    t_key        w_req_key;
    logic        w_in_acc;
    logic        w_full;
    logic        w_found;
    t_cell_ctl   w_ctl;

    t_key        w_keys   [CAPACITY];
    t_cell_flags w_flags  [CAPACITY];
    t_key        w_lasts  [CAPACITY];
    logic [CAPACITY-1:0] w_first_eq;
    t_key        w_largest;

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_pend;
    logic [1:0]    r_pend_status;
    logic          r_pend_hit;
    logic [1:0]    n_status;
    logic          n_hit;
    logic          w_out_load;
    logic          r_out_valid;
    logic [79:0]   r_out_data;
    logic          w_empty;

    assign w_mode    = i_s_axis_tdata[1:0];
    assign w_req_key = i_s_axis_tdata[33:2];

    // A new request waits until the previous result has left the row, and
    // nothing is taken while reset is held.
    assign o_s_axis_tready = i_rst_n && !r_pend;
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;

    assign w_full  = r_count == CW'(CAPACITY);
    assign w_found = |w_first_eq;

    // Row control for this request.
    assign w_ctl.key    = w_req_key;
    assign w_ctl.do_ins = w_in_acc && (w_mode == MODE_INSERT) && !w_full;
    assign w_ctl.do_rem = w_in_acc && (w_mode == MODE_REMOVE) && w_found;

    // Chain of key cells, each linked to its two neighbors.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_key        w_left_key;
        t_cell_flags w_left_flags;
        t_key        w_right_key;

        if (g == 0) begin : g_head
            assign w_left_key      = '0;
            assign w_left_flags.le = 1'b1;
            assign w_left_flags.lt = 1'b1;
        end else begin : g_body
            assign w_left_key   = w_keys[g-1];
            assign w_left_flags = w_flags[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_right_key = '0;
        end else begin : g_mid
            assign w_right_key = w_keys[g+1];
        end

        smset_cell #(
            .CW  (CW),
            .IDX (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_count      (r_count),
            .i_left_key   (w_left_key),
            .i_left_flags (w_left_flags),
            .i_right_key  (w_right_key),
            .o_key        (w_keys[g]),
            .o_flags      (w_flags[g]),
            .o_first_eq   (w_first_eq[g]),
            .o_last_key   (w_lasts[g])
        );
    end

    // The one slot flagged as last supplies the largest key.
    always_comb begin
        w_largest = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_largest = w_largest | w_lasts[i];
        end
    end

    // Count update and per-request status.
    always_comb begin
        n_count  = r_count;
        n_status = ST_DONE;
        n_hit    = 1'b0;
        case (w_mode)
            MODE_INSERT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            MODE_REMOVE: begin
                if (w_found) begin
                    n_count = r_count - CW'(1);
                    n_hit   = 1'b1;
                end else begin
                    n_status = ST_MISSING;
                end
            end
            MODE_SEARCH: begin
                n_hit = w_found;
            end
            MODE_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // Count and pending result state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_count <= n_count;
                r_pend  <= 1'b1;
            end else if (w_out_load) begin
                r_pend <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_pend_status <= n_status;
            r_pend_hit    <= n_hit;
        end
    end

    // Output register, filled from the updated row once it is free.
    assign w_out_load = r_pend && (!r_out_valid || i_m_axis_tready);
    assign w_empty    = r_count == '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data <= {7'd0, w_empty, w_largest,
                           w_empty ? t_key'(0) : w_keys[0],
                           5'(r_count), r_pend_hit, r_pend_status};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // The key count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("key count above capacity");

    // At most one slot can be the first match of a key.
    a_one_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_first_eq))
        else $error("several first-match slots");

    // An insert into a store with room grows the count by one.
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.do_ins |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the count");

    // A taken request always leaves a result pending or loaded.
    a_pend_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_pend)
        else $error("request without pending result");

endmodule

/* tb/sorted_multiset_store_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted multiset store testbench
// Drives insert, remove, search and clear requests into the store and checks
// every result against a shadow copy of the sorted key row kept in the bench.
// Directed requests cover empty and full stores, duplicates and the key
// extremes. Random requests then mix held and random keys while
// both sides stall at random, with one long output hold-off and one drain.
// ----------------------------------------------------------------------------
module sorted_multiset_store_test;
    import smset_pkg::*;

    localparam int   CAPACITY = 16;
    localparam t_key KEY_MAX  = 32'sh7FFF_FFFF;
    localparam t_key KEY_MIN  = 32'sh8000_0000;

    // One result as the store reports it.
    typedef struct {
        logic [1:0] status;
        logic       hit;
        logic [4:0] count;
        t_key       smallest;
        t_key       largest;
        logic       is_empty;
    } t_store_result;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [39:0] s_tdata  = '0;
    logic        m_tready = 1'b0;
    logic        m_hold   = 1'b0;
    logic        sink_idle_en = 1'b1;
    bit          src_idle_en  = 1'b1;
    wire         s_tready;
    wire         m_tvalid;
    wire  [79:0] m_tdata;

    // Shadow of the key row and the results it predicts.
    t_key          shadow_keys [CAPACITY];
    int            shadow_count = 0;
    t_store_result expected_results [$];

    int errors          = 0;
    int results_checked = 0;
    int full_seen       = 0;
    int missing_seen    = 0;
    int mode_seen [4]   = '{0, 0, 0, 0};
    int gap_left        = 0;

    sorted_multiset_store #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        // Fields from bit 0: mode[1:0], key[33:2], zero fill[39:34].
        .i_s_axis_tdata (s_tdata),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        // Fields from bit 0: status[1:0], hit[2], count[7:3], smallest[39:8],
        // largest[71:40], is_empty[72], zero fill[79:73].
        .o_m_axis_tdata (m_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Safety net against a hung handshake.
    initial begin
        #2_000_000;
        $display("** sorted_multiset_store: FAILED **");
        $finish;
    end

    // Apply one request to the shadow row and return the result it should give.
    function automatic t_store_result apply_to_shadow(input logic [1:0] mode,
                                                      input t_key key);
        t_store_result r;
        int pos;
        int i;
        r.status = ST_DONE;
        r.hit    = 1'b0;
        case (mode)
            MODE_INSERT: begin
                if (shadow_count >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    // Equal keys stay ahead of the new one.
                    pos = 0;
                    while (pos < shadow_count && shadow_keys[pos] <= key) pos++;
                    for (i = shadow_count; i > pos; i--) shadow_keys[i] = shadow_keys[i-1];
                    shadow_keys[pos] = key;
                    shadow_count++;
                end
            end
            MODE_REMOVE: begin
                pos = 0;
                while (pos < shadow_count && shadow_keys[pos] != key) pos++;
                if (pos < shadow_count) begin
                    for (i = pos; i + 1 < shadow_count; i++) shadow_keys[i] = shadow_keys[i+1];
                    shadow_count--;
                    r.hit = 1'b1;
                end else begin
                    r.status = ST_MISSING;
                end
            end
            MODE_SEARCH: begin
                for (i = 0; i < shadow_count; i++) begin
                    if (shadow_keys[i] == key) r.hit = 1'b1;
                end
            end
            default: begin
                shadow_count = 0;
            end
        endcase
        r.count = shadow_count[4:0];
        if (shadow_count == 0) begin
            r.smallest = '0;
            r.largest  = '0;
            r.is_empty = 1'b1;
        end else begin
            r.smallest = shadow_keys[0];
            r.largest  = shadow_keys[shadow_count-1];
            r.is_empty = 1'b0;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                   input logic [31:0] want_v);
        errors++;
        if (errors <= 30) begin
            $display("%0t ns: %s mismatch, got %0h, expected %0h", $time, what, got_v, want_v);
        end
    endtask

    // Offer one request, with an occasional gap before it, until it is taken.
    task automatic send_request(input logic [1:0] mode, input t_key key);
        if (src_idle_en && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, key, mode};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        expected_results.push_back(apply_to_shadow(mode, key));
        mode_seen[mode]++;
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    // Keys are mostly held ones or a small pool so removes and searches hit.
    function automatic t_key pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (shadow_count > 0 && r < 45) return shadow_keys[$urandom_range(0, shadow_count-1)];
        if (r < 60) return KEY_MIN + $urandom_range(0, 2);
        if (r < 70) return KEY_MAX - $urandom_range(0, 2);
        if (r < 85) return $signed($urandom_range(0, 8)) - 4;
        return $urandom;
    endfunction

    // Receiver: long hold-off on request, random stall bursts otherwise.
    always @(posedge i_clk) begin
        if (!i_rst_n || m_hold) begin
            m_tready <= 1'b0;
        end else if (gap_left > 0) begin
            m_tready <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
            m_tready <= 1'b0;
            gap_left <= $urandom_range(0, 9);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Result checker: each taken result against the oldest expectation.
    always @(posedge i_clk) begin
        t_store_result got;
        t_store_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got.status   = m_tdata[1:0];
            got.hit      = m_tdata[2];
            got.count    = m_tdata[7:3];
            got.smallest = m_tdata[39:8];
            got.largest  = m_tdata[71:40];
            got.is_empty = m_tdata[72];
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", m_tdata[31:0], '0);
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                if (want.status == ST_FULL) full_seen++;
                if (want.status == ST_MISSING) missing_seen++;
                if (got.status !== want.status) report_mismatch("status", got.status, want.status);
                if (got.hit !== want.hit) report_mismatch("hit", got.hit, want.hit);
                if (got.count !== want.count) report_mismatch("count", got.count, want.count);
                if (got.smallest !== want.smallest) begin
                    report_mismatch("smallest", got.smallest, want.smallest);
                end
                if (got.largest !== want.largest) begin
                    report_mismatch("largest", got.largest, want.largest);
                end
                if (got.is_empty !== want.is_empty) begin
                    report_mismatch("is_empty", got.is_empty, want.is_empty);
                end
            end
        end
    end

    // Empty store, extreme keys, duplicates and removes of absent keys.
    task automatic test_basic_operations();
        send_request(MODE_SEARCH, KEY_MIN);
        send_request(MODE_REMOVE, KEY_MAX);
        send_request(MODE_CLEAR, 32'sd0);
        send_request(MODE_INSERT, 32'sd0);
        send_request(MODE_INSERT, KEY_MAX);
        send_request(MODE_INSERT, KEY_MIN);
        send_request(MODE_INSERT, 32'sd0);
        send_request(MODE_SEARCH, KEY_MIN);
        send_request(MODE_REMOVE, 32'sd0);
        send_request(MODE_REMOVE, 32'sd5);
        send_request(MODE_REMOVE, KEY_MAX);
    endtask

    // Fill to capacity, then inserts are dropped until a key leaves.
    task automatic test_full_store();
        int i;
        i = 0;
        while (shadow_count < CAPACITY) begin
            send_request(MODE_INSERT, -(i % 5) - 1);
            i++;
        end
        send_request(MODE_INSERT, KEY_MAX);
        send_request(MODE_INSERT, KEY_MIN);
        send_request(MODE_REMOVE, -32'sd3);
        send_request(MODE_INSERT, KEY_MAX);
        send_request(MODE_SEARCH, -32'sd3);
        send_request(MODE_CLEAR, KEY_MAX);
    endtask

    task automatic run_random(input int n);
        int k;
        int r;
        int ins_w;
        logic [1:0] mode;
        ins_w = 50;
        for (k = 0; k < n; k++) begin
            // Swing between filling and draining phases.
            if (k % 40 == 0) ins_w = ($urandom_range(0, 2) == 0) ? 25 : 75;
            r = $urandom_range(0, 99);
            if (r < ins_w) mode = MODE_INSERT;
            else if (r < ins_w + (97 - ins_w) / 2) mode = MODE_REMOVE;
            else if (r < 97) mode = MODE_SEARCH;
            else mode = MODE_CLEAR;
            send_request(mode, pick_key());
        end
    endtask

    // The receiver holds off long enough that the store stalls its input.
    task automatic test_output_backpressure();
        src_idle_en = 1'b0;
        fork
            begin
                m_hold <= 1'b1;
                repeat (300) @(posedge i_clk);
                m_hold <= 1'b0;
            end
            run_random(40);
        join
        src_idle_en = 1'b1;
    endtask

    // The sender stops until every result is back, then resumes.
    task automatic test_drain_pause();
        run_random(15);
        wait_for_drain();
        run_random(15);
    endtask

    task automatic test_random_traffic();
        run_random(1000);
    endtask

    // Last stretch at full rate on both sides.
    task automatic test_full_rate();
        src_idle_en = 1'b0;
        sink_idle_en <= 1'b0;
        run_random(250);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_basic_operations();
        test_full_store();
        test_output_backpressure();
        test_drain_pause();
        test_random_traffic();
        test_full_rate();
        wait_for_drain();
        repeat (10) @(posedge i_clk);
        $display("Requests: %0d insert, %0d remove, %0d search, %0d clear; %0d results checked.",
                 mode_seen[MODE_INSERT], mode_seen[MODE_REMOVE], mode_seen[MODE_SEARCH],
                 mode_seen[MODE_CLEAR], results_checked);
        $display("Dropped inserts on a full store: %0d, removes of absent keys: %0d.",
                 full_seen, missing_seen);
        if (errors == 0) begin
            $display("** sorted_multiset_store: PASSED **");
        end else begin
            $display("** sorted_multiset_store: FAILED **");
        end
        $finish;
    end

endmodule
